// ===== hw/rtl/pn23_pkg.sv =====
// Package: hash constants and mixer functions for the gradient noise pipeline.
`timescale 1ns / 1ps
`default_nettype none
package pn23_pkg;
    localparam logic [31:0] HASH_MUL  = 32'h27d4eb2d;
    localparam logic [31:0] HASH_GOLD = 32'h9e3779b9;
    localparam logic [31:0] HASH_XOR  = 32'd61;

    // First half of the integer mixer, before the multiply.
    function automatic logic [31:0] mix_pre(input logic [31:0] a_in);
        logic [31:0] a;
        a = (a_in ^ HASH_XOR) ^ (a_in >> 16);
        a = a + (a << 3);
        a = a ^ (a >> 4);
        return a;
    endfunction

    // Second half of the mixer, after the multiply.
    function automatic logic [31:0] mix_post(input logic [31:0] a);
        return a ^ (a >> 15);
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/perlin_noise_2d_3d.sv =====
// Top level: seeded 2D/3D gradient noise, fully pipelined.
// One new sample may start every cycle.
// Throughput: one sample per cycle, set by the per-stage hash mixer and fade multipliers.
// busy is always low: the receiver cannot stall, so nothing backs up.
// Reset (synchronous, active low) clears the valid pipeline and sets the seed to 0.
`timescale 1ns / 1ps
`default_nettype none
module perlin_noise_2d_3d #(
    parameter int FRAC_BITS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               i_cfg_we,
    input  wire        [31:0] i_cfg_wdata,
    input  wire signed [31:0] i_coord_x,
    input  wire signed [31:0] i_coord_y,
    input  wire signed [31:0] i_coord_z,
    input  wire               i_three_dim,
    output logic              o_valid,
    output logic signed [18:0] o_noise_value
);
    localparam int  F   = FRAC_BITS;
    localparam int  VW  = F + 6;            // value width for grads, lerps
    localparam int  NL  = 26;               // pipeline depth
    localparam int  NC  = 8;                // corners
    localparam logic signed [VW-1:0] ONE = VW'(1) <<< F;

    typedef logic signed [VW-1:0] t_val;
    typedef logic [31:0] t_word;

    assign busy = 1'b0;

    // Seed register
    logic [31:0] r_seed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= '0;
        else if (i_cfg_we) r_seed <= i_cfg_wdata;
    end

    // Valid shift line
    logic [NL-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[NL-2:0], start};
    end

    // Stage 0: split coordinates into cell and fraction
    logic [7:0]  r_cx, r_cy, r_cz;
    t_val        r_fx, r_fy, r_fz;
    logic        r_d3;
    logic [31:0] r_sd;
    always_ff @(posedge i_clk) begin
        r_cx <= 8'(i_coord_x >>> F);
        r_cy <= 8'(i_coord_y >>> F);
        r_cz <= 8'(i_coord_z >>> F);
        r_fx <= VW'({1'b0, i_coord_x[F-1:0]});
        r_fy <= VW'({1'b0, i_coord_y[F-1:0]});
        r_fz <= VW'({1'b0, i_coord_z[F-1:0]});
        r_d3 <= i_three_dim;
        r_sd <= r_seed;
    end

    // Hash chain: 4 mixes (x, y, z, final), each in 3 stages; the z mix is skipped in 2D.
    // Stage layout per mix: A) add/pre-mix  B) multiply  C) post-mix and xor (final mix: post-mix only).
    t_word r_h  [13][NC];
    t_word r_m  [13][NC];
    logic  [7:0] r_hx [13], r_hy [13], r_hz [13];
    logic  r_hd [13];
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            r_h[0][c] <= r_sd;
            r_m[0][c] <= '0;
        end
        r_hx[0] <= r_cx; r_hy[0] <= r_cy; r_hz[0] <= r_cz; r_hd[0] <= r_d3;
        for (int s = 1; s < 13; s++) begin
            r_hx[s] <= r_hx[s-1]; r_hy[s] <= r_hy[s-1];
            r_hz[s] <= r_hz[s-1]; r_hd[s] <= r_hd[s-1];
            for (int c = 0; c < NC; c++) begin
                logic [31:0] key;
                logic [1:0]  mi;
                int          ph;
                logic [31:0] hn;
                mi  = (s <= 3) ? 2'd0 : (s <= 6) ? 2'd1 : (s <= 9) ? 2'd2 : 2'd3;
                ph  = s - 1 - 3 * int'(mi);
                case (mi)
                    2'd0:    key = 32'(r_hx[s-1]) + 32'(c & 1);
                    2'd1:    key = 32'(r_hy[s-1]) + 32'((c >> 1) & 1);
                    2'd2:    key = 32'(r_hz[s-1]) + 32'((c >> 2) & 1);
                    default: key = '0;
                endcase
                hn = r_h[s-1][c];
                case (ph)
                    0: begin
                        if (mi == 2'd0)
                            r_m[s][c] <= pn23_pkg::mix_pre(key + pn23_pkg::HASH_GOLD);
                        else if (mi == 2'd3)
                            r_m[s][c] <= pn23_pkg::mix_pre(r_h[s-1][c]);
                        else
                            r_m[s][c] <= pn23_pkg::mix_pre(key + pn23_pkg::HASH_GOLD
                                                           + r_h[s-1][c]);
                    end
                    1: r_m[s][c] <= r_m[s-1][c] * pn23_pkg::HASH_MUL;
                    default: begin
                        if (mi == 2'd3)
                            hn = pn23_pkg::mix_post(r_m[s-1][c]);
                        else if (!(mi == 2'd2 && !r_hd[s-1]))
                            hn = r_h[s-1][c] ^ pn23_pkg::mix_post(r_m[s-1][c]);
                        r_m[s][c] <= r_m[s-1][c];
                    end
                endcase
                r_h[s][c] <= hn;
            end
        end
    end

    // Fraction delay line alongside the hash chain
    t_val r_dx [NL], r_dy [NL], r_dz [NL];
    logic r_dd [NL];
    always_ff @(posedge i_clk) begin
        r_dx[0] <= r_fx; r_dy[0] <= r_fy; r_dz[0] <= r_fz; r_dd[0] <= r_d3;
        for (int s = 1; s < NL; s++) begin
            r_dx[s] <= r_dx[s-1]; r_dy[s] <= r_dy[s-1];
            r_dz[s] <= r_dz[s-1]; r_dd[s] <= r_dd[s-1];
        end
    end

    // Fade: at most one rounded product per stage, then a clamp to [0, ONE]
    function automatic t_val mulq(input t_val a, input t_val b);
        logic signed [2*VW-1:0] p;
        p = (2*VW)'(a) * (2*VW)'(b) + ((2*VW)'(1) <<< (F-1));
        return VW'(p >>> F);
    endfunction

    t_val r_fp [3][6];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            t_val t0, t1, t2, t3, t4;
            t0 = (k == 0) ? r_fx : (k == 1) ? r_fy : r_fz;
            t1 = (k == 0) ? r_dx[0] : (k == 1) ? r_dy[0] : r_dz[0];
            t2 = (k == 0) ? r_dx[1] : (k == 1) ? r_dy[1] : r_dz[1];
            t3 = (k == 0) ? r_dx[2] : (k == 1) ? r_dy[2] : r_dz[2];
            t4 = (k == 0) ? r_dx[3] : (k == 1) ? r_dy[3] : r_dz[3];
            r_fp[k][0] <= VW'(6) * t0 - VW'(15) * ONE;
            r_fp[k][1] <= mulq(r_fp[k][0], t1) + VW'(10) * ONE;
            r_fp[k][2] <= mulq(r_fp[k][1], t2);
            r_fp[k][3] <= mulq(r_fp[k][2], t3);
            r_fp[k][4] <= mulq(r_fp[k][3], t4);
            if (r_fp[k][4] < 0)        r_fp[k][5] <= '0;
            else if (r_fp[k][4] > ONE) r_fp[k][5] <= ONE;
            else                       r_fp[k][5] <= r_fp[k][4];
        end
    end

    // Fade weights held until the lerp stages
    t_val r_wu [NL], r_wv [NL], r_ww [NL];
    always_ff @(posedge i_clk) begin
        r_wu[0] <= r_fp[0][5]; r_wv[0] <= r_fp[1][5]; r_ww[0] <= r_fp[2][5];
        for (int s = 1; s < NL; s++) begin
            r_wu[s] <= r_wu[s-1]; r_wv[s] <= r_wv[s-1]; r_ww[s] <= r_ww[s-1];
        end
    end
    // Fade result r_fp[.][5] enters the weight delay line at r_wu[0].

    // Gradients at hash stage 12 (stage index 13 after stage 0)
    localparam int GS = 13;
    function automatic t_val grad(input logic [31:0] h, input logic d3,
                                  input t_val x, input t_val y, input t_val z);
        t_val u, v;
        logic [3:0] g;
        g = h[3:0];
        if (!d3) begin
            u = (g[1:0] < 2'd2) ? x : y;
            v = (g[1:0] < 2'd2) ? y : x;
            return (g[0] ? -u : u) + (g[1] ? -(v <<< 1) : (v <<< 1));
        end
        u = (g < 4'd8) ? x : y;
        v = (g < 4'd4) ? y : ((g == 4'd12 || g == 4'd14) ? x : z);
        return (g[0] ? -u : u) + (g[1] ? -v : v);
    endfunction

    t_val r_g [NC];
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            t_val x, y, z;
            x = r_dx[GS-1] - (((c & 1) != 0) ? ONE : '0);
            y = r_dy[GS-1] - (((c & 2) != 0) ? ONE : '0);
            z = r_dz[GS-1] - (((c & 4) != 0) ? ONE : '0);
            r_g[c] <= grad(r_h[12][c], r_dd[GS-1], x, y, z);
        end
    end

    // Lerp stages per level: difference, then multiply and add, then a holding register
    t_val r_l1a [4], r_l1d [4], r_l1p [4], r_l1 [4];
    t_val r_l2a [2], r_l2d [2], r_l2p [2], r_l2 [2];
    t_val r_l3a, r_l3d, r_l3p, r_l3;
    t_val r_l2q [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_l1a[i] <= r_g[2*i];
            r_l1d[i] <= r_g[2*i+1] - r_g[2*i];
            r_l1p[i] <= r_l1a[i] + mulq(r_wu[GS-5], r_l1d[i]);
            r_l1[i]  <= r_l1p[i];
        end
        for (int i = 0; i < 2; i++) begin
            r_l2a[i] <= r_l1[2*i];
            r_l2d[i] <= r_l1[2*i+1] - r_l1[2*i];
            r_l2p[i] <= r_l2a[i] + mulq(r_wv[GS-2], r_l2d[i]);
            r_l2[i]  <= r_l2p[i];
        end
        r_l3a <= r_l2[0];
        r_l3d <= r_l2[1] - r_l2[0];
        r_l3p <= r_l3a + mulq(r_ww[GS+1], r_l3d);
        r_l3  <= r_l3p;
        // 2D result delayed to line up with the third level
        r_l2q[0] <= r_l2[0];
        r_l2q[1] <= r_l2q[0];
        r_l2q[2] <= r_l2q[1];
    end

    // Remap (n+1)/2 with saturation; 2D takes the second-level result
    t_val r_n;
    always_ff @(posedge i_clk) begin
        if (r_dd[GS+9]) r_n <= r_l3;
        else            r_n <= r_l2q[2];
    end
    logic signed [VW:0] w_s;
    assign w_s = ((VW+1)'(r_n) + (VW+1)'(ONE) + (VW+1)'(1)) >>> 1;
    always_ff @(posedge i_clk) begin
        if (w_s > 262143)       o_noise_value <= 19'sd262143;
        else if (w_s < -262144) o_noise_value <= -19'sd262144;
        else                    o_noise_value <= 19'(w_s);
    end
    assign o_valid = r_vld[NL-1];
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for perlin_noise_2d_3d: scoreboard of predicted noise samples vs. the pipeline.
`timescale 1ns / 1ps
module testbench;
    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 <<< FRAC;
    localparam logic [31:0] GOLD = 32'h9e3779b9;
    localparam logic [31:0] MIX_MUL = 32'h27d4eb2d;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic signed [31:0] i_coord_x, i_coord_y, i_coord_z;
    logic i_three_dim;
    logic o_valid;
    logic signed [18:0] o_noise_value;

    logic [31:0] seed_shadow;
    logic signed [18:0] expected_noise[$];
    int mismatches;

    perlin_noise_2d_3d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_three_dim(i_three_dim), .o_valid(o_valid), .o_noise_value(o_noise_value)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Integer mixer used for the lattice corner hash
    function automatic logic [31:0] mix_word(input logic [31:0] a_in);
        logic [31:0] a;
        a = (a_in ^ 32'd61) ^ (a_in >> 16);
        a = a + (a << 3);
        a = a ^ (a >> 4);
        a = a * MIX_MUL;
        return a ^ (a >> 15);
    endfunction

    function automatic logic [31:0] corner_hash(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z, input bit use_z);
        logic [31:0] h;
        h = seed_shadow;
        h ^= mix_word(x + GOLD);
        h ^= mix_word(y + GOLD + h);
        if (use_z) h ^= mix_word(z + GOLD + h);
        return mix_word(h);
    endfunction

    // Rounded fixed-point product, half up
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint fade_weight(input longint t);
        longint p;
        p = 6 * t - 15 * ONE;
        p = fx_mul(p, t) + 10 * ONE;
        p = fx_mul(p, t);
        p = fx_mul(p, t);
        p = fx_mul(p, t);
        if (p < 0) p = 0;
        if (p > ONE) p = ONE;
        return p;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint t);
        return a + fx_mul(t, b - a);
    endfunction

    function automatic longint grad_2d(input logic [31:0] hash, input longint x, input longint y);
        logic [1:0] h;
        longint u, v;
        h = hash[1:0];
        u = h < 2 ? x : y;
        v = h < 2 ? y : x;
        return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
    endfunction

    function automatic longint grad_3d(input logic [31:0] hash, input longint x, input longint y,
                                       input longint z);
        logic [3:0] h;
        longint u, v;
        h = hash[3:0];
        u = h < 8 ? x : y;
        v = h < 4 ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // Expected noise sample for one coordinate
    function automatic logic signed [18:0] noise_predict(input logic signed [31:0] cx,
            input logic signed [31:0] cy, input logic signed [31:0] cz, input bit dim3);
        longint fx, fy, fz, u, v, w, n, s, a, b, c, d;
        logic [31:0] gx, gy, gz;
        fx = longint'(cx) >>> FRAC;  fy = longint'(cy) >>> FRAC;  fz = longint'(cz) >>> FRAC;
        gx = 32'(fx & 255);  gy = 32'(fy & 255);  gz = 32'(fz & 255);
        fx = longint'(cx) - (fx <<< FRAC);
        fy = longint'(cy) - (fy <<< FRAC);
        fz = longint'(cz) - (fz <<< FRAC);
        u = fade_weight(fx);
        v = fade_weight(fy);
        if (dim3) begin
            w = fade_weight(fz);
            a = blend(grad_3d(corner_hash(gx, gy, gz, 1), fx, fy, fz),
                      grad_3d(corner_hash(gx + 1, gy, gz, 1), fx - ONE, fy, fz), u);
            b = blend(grad_3d(corner_hash(gx, gy + 1, gz, 1), fx, fy - ONE, fz),
                      grad_3d(corner_hash(gx + 1, gy + 1, gz, 1), fx - ONE, fy - ONE, fz), u);
            c = blend(grad_3d(corner_hash(gx, gy, gz + 1, 1), fx, fy, fz - ONE),
                      grad_3d(corner_hash(gx + 1, gy, gz + 1, 1), fx - ONE, fy, fz - ONE), u);
            d = blend(grad_3d(corner_hash(gx, gy + 1, gz + 1, 1), fx, fy - ONE, fz - ONE),
                      grad_3d(corner_hash(gx + 1, gy + 1, gz + 1, 1),
                              fx - ONE, fy - ONE, fz - ONE), u);
            n = blend(blend(a, b, v), blend(c, d, v), w);
        end else begin
            a = blend(grad_2d(corner_hash(gx, gy, 0, 0), fx, fy),
                      grad_2d(corner_hash(gx + 1, gy, 0, 0), fx - ONE, fy), u);
            b = blend(grad_2d(corner_hash(gx, gy + 1, 0, 0), fx, fy - ONE),
                      grad_2d(corner_hash(gx + 1, gy + 1, 0, 0), fx - ONE, fy - ONE), u);
            n = blend(a, b, v);
        end
        s = (n + ONE + 1) >>> 1;
        if (s > 262143) s = 262143;
        if (s < -262144) s = -262144;
        return 19'(s);
    endfunction

    // Send one sample; start stays high for a back-to-back transfer
    task automatic send_sample(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input bit dim3);
        @(negedge i_clk);
        i_coord_x <= cx;
        i_coord_y <= cy;
        i_coord_z <= cz;
        i_three_dim <= dim3;
        start <= 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        expected_noise.push_back(noise_predict(cx, cy, cz, dim3));
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Seed write only once the pipeline has drained
    task automatic write_seed(input logic [31:0] seed);
        idle_gap(1);
        while (expected_noise.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= seed;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        seed_shadow = seed;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 8;
            2: return {16'($urandom_range(3) == 0 ? 16'hffff : 16'($urandom_range(300))),
                       16'($urandom)};
            default: return {$urandom_range(1) ? 16'h8000 : 16'h7fff, 16'($urandom)};
        endcase
    endfunction

    // Directed: extremes, cell wrap at 255, negative floor, both dimensions
    task automatic test_directed();
        logic [31:0] pts[] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                               32'h00ff8000, 32'h00ffffff, 32'hffff0001, 32'h00010000,
                               32'h00008000, 32'h0000ffff, 32'h12345678};
        for (int i = 0; i < pts.size(); i++) begin
            send_sample(pts[i], pts[(i + 3) % pts.size()], pts[(i + 5) % pts.size()], 0);
            send_sample(pts[i], pts[(i + 3) % pts.size()], pts[(i + 5) % pts.size()], 1);
        end
        idle_gap(1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_sample(rand_coord(), rand_coord(), rand_coord(), $urandom_range(1));
            idle_gap(i % 50 < 20 ? 0 : pick_gap());
        end
        idle_gap(1);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_noise.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", o_noise_value);
            end else begin
                if (o_noise_value !== expected_noise[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d got %0d",
                                 expected_noise[0], o_noise_value);
                end
                void'(expected_noise.pop_front());
            end
        end
    end

    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        mismatches = 0;
        seed_shadow = 32'h0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 32'h0;
        i_coord_x = 32'h0;
        i_coord_y = 32'h0;
        i_coord_z = 32'h0;
        i_three_dim = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        write_seed(32'hffffffff);
        test_directed();
        test_random(200);
        write_seed(32'h0);
        test_random(200);
        write_seed($urandom);
        test_random(200);
        write_seed($urandom);
        test_random(200);

        idle_gap(1);
        while (expected_noise.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_noise.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
